FILE: rtl/lgs_pkg.sv
// Shared types and codes for the toroidal life grid block.
package lgs_pkg;

   localparam int CMD_WIDTH = 2;
   localparam int ROW_WIDTH = 7;
   localparam int COL_WIDTH = 7;

   typedef enum logic [CMD_WIDTH-1:0] {
      CMD_WRITE = 2'd0,
      CMD_READ  = 2'd1,
      CMD_STEP  = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      OP_NOP,
      OP_WRITE,
      OP_READ,
      OP_STEP
   } op_type;

   typedef struct packed {
      logic [CMD_WIDTH-1:0] cmd;
      logic [ROW_WIDTH-1:0] row;
      logic [COL_WIDTH-1:0] col;
      logic                 value;
   } req_payload_type;

   typedef struct packed {
      logic [CMD_WIDTH-1:0] done_cmd;
      logic                 alive;
   } rsp_payload_type;

   typedef struct packed {
      op_type               op;
      logic [CMD_WIDTH-1:0] done_cmd;
      logic [ROW_WIDTH-1:0] row;
      logic [COL_WIDTH-1:0] col;
      logic                 value;
   } task_type;

   typedef struct packed {
      logic     valid;
      task_type entry;
   } queue_head_type;

endpackage

FILE: rtl/lgs_if.sv
// Valid/ready channel interfaces for the request and response sides.
interface lgs_req_if;
   logic                     valid;
   logic                     ready;
   lgs_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface lgs_rsp_if;
   logic                     valid;
   logic                     ready;
   lgs_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/lgs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lgs_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

FILE: rtl/lgs_front.sv
// Front end: accept request beats, decode them into tasks and queue them.
module lgs_front #(
   parameter int GRID_WIDTH  = 128,
   parameter int GRID_HEIGHT = 128
) (
   input  logic                    clock,
   input  logic                    reset,
   lgs_req_if.sink                 req_chan,
   input  logic                    clearing,
   input  logic                    pop,
   output lgs_pkg::queue_head_type head
);
   import lgs_pkg::*;

   localparam int QueueDepth = 2;
   localparam int PtrW       = $clog2(QueueDepth);
   localparam int CountW     = $clog2(QueueDepth + 1);
   localparam logic [PtrW-1:0]   PtrLast = PtrW'(QueueDepth - 1);
   localparam logic [CountW-1:0] CountFull = CountW'(QueueDepth);

   task_type            queue_ff [QueueDepth];
   logic [PtrW-1:0]     wr_ptr_ff;
   logic [PtrW-1:0]     rd_ptr_ff;
   logic [CountW-1:0]   count_ff;
   task_type            decoded;
   logic                on_grid;
   logic                push;
   logic                do_pop;

   always_comb begin
      on_grid = (int'(req_chan.payload.row) < GRID_HEIGHT) &&
                (int'(req_chan.payload.col) < GRID_WIDTH);
      decoded.done_cmd = req_chan.payload.cmd;
      decoded.row      = req_chan.payload.row;
      decoded.col      = req_chan.payload.col;
      decoded.value    = req_chan.payload.value;
      unique case (req_chan.payload.cmd)
         CMD_WRITE: decoded.op = on_grid ? OP_WRITE : OP_NOP;
         CMD_READ:  decoded.op = on_grid ? OP_READ : OP_NOP;
         CMD_STEP:  decoded.op = OP_STEP;
         default:   decoded.op = OP_NOP;
      endcase
   end

   assign req_chan.ready = (count_ff != CountFull) && !clearing;
   assign push           = req_chan.valid && req_chan.ready;
   assign do_pop         = pop && (count_ff != '0);
   assign head.valid     = count_ff != '0;
   assign head.entry     = queue_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            queue_ff[wr_ptr_ff] <= decoded;
            wr_ptr_ff <= (wr_ptr_ff == PtrLast) ? '0 : wr_ptr_ff + PtrW'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PtrLast) ? '0 : rd_ptr_ff + PtrW'(1);
         end
         if (push && !do_pop) begin
            count_ff <= count_ff + CountW'(1);
         end else if (do_pop && !push) begin
            count_ff <= count_ff - CountW'(1);
         end
      end
   end

endmodule

FILE: rtl/lgs_back.sv
// Back end: grid banks, row-wide generation sweep and the response register.
module lgs_back #(
   parameter int GRID_WIDTH  = 128,
   parameter int GRID_HEIGHT = 128
) (
   input  logic                    clock,
   input  logic                    reset,
   input  lgs_pkg::queue_head_type head,
   output logic                    pop,
   output logic                    clearing,
   lgs_rsp_if.source               rsp_chan
);
   import lgs_pkg::*;

   localparam int RowAw = $clog2(GRID_HEIGHT);
   localparam int ColAw = $clog2(GRID_WIDTH);
   localparam int StepW = $clog2(GRID_HEIGHT + 4);
   localparam logic [RowAw-1:0] RowLast  = RowAw'(GRID_HEIGHT - 1);
   localparam logic [StepW-1:0] StepOne  = StepW'(1);
   localparam logic [StepW-1:0] StepFill = StepW'(4);
   localparam logic [StepW-1:0] StepRows = StepW'(GRID_HEIGHT);
   localparam logic [StepW-1:0] StepLast = StepW'(GRID_HEIGHT + 3);

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_CELL,
      S_STEP
   } state_type;

   state_type             state_ff;
   logic                  bank_ff;
   logic [RowAw-1:0]      clr_row_ff;
   logic [StepW-1:0]      step_cnt_ff;
   logic [RowAw-1:0]      row_ff;
   logic [ColAw-1:0]      col_ff;
   logic                  value_ff;
   logic                  write_ff;
   logic                  rsp_valid_ff;
   rsp_payload_type       rsp_payload_ff;
   logic [GRID_WIDTH-1:0] win_up_ff;
   logic [GRID_WIDTH-1:0] win_mid_ff;
   logic [GRID_WIDTH-1:0] win_dn_ff;

   logic [RowAw-1:0]      rd_addr;
   logic [RowAw-1:0]      wr_addr;
   logic [GRID_WIDTH-1:0] wr_data;
   logic [GRID_WIDTH-1:0] rd_data_a;
   logic [GRID_WIDTH-1:0] rd_data_b;
   logic [GRID_WIDTH-1:0] word;
   logic [GRID_WIDTH-1:0] next_row;
   logic                  wr_cur;
   logic                  wr_other;
   logic                  wr_both;
   logic                  wr_a;
   logic                  wr_b;
   logic                  out_free;

   lgs_ram #(.WIDTH(GRID_WIDTH), .DEPTH(GRID_HEIGHT)) u_bank_a (
      .clock   (clock),
      .wr_en   (wr_a),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data_a)
   );

   lgs_ram #(.WIDTH(GRID_WIDTH), .DEPTH(GRID_HEIGHT)) u_bank_b (
      .clock   (clock),
      .wr_en   (wr_b),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data_b)
   );

   for (genvar j = 0; j < GRID_WIDTH; j++) begin : g_cell
      localparam int Lf = (j + GRID_WIDTH - 1) % GRID_WIDTH;
      localparam int Rt = (j + 1) % GRID_WIDTH;
      logic [3:0] count;
      assign count = 4'(win_up_ff[Lf]) + 4'(win_up_ff[j]) + 4'(win_up_ff[Rt]) +
                     4'(win_mid_ff[Lf]) + 4'(win_mid_ff[Rt]) +
                     4'(win_dn_ff[Lf]) + 4'(win_dn_ff[j]) + 4'(win_dn_ff[Rt]);
      assign next_row[j] = (count == 4'd3) || (win_mid_ff[j] && (count == 4'd2));
   end

   assign word     = bank_ff ? rd_data_b : rd_data_a;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign pop      = (state_ff == S_IDLE) && head.valid && out_free;
   assign clearing = state_ff == S_CLEAR;

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_payload_ff;

   always_comb begin
      rd_addr  = RowAw'(head.entry.row);
      wr_addr  = row_ff;
      wr_data  = word;
      wr_cur   = 1'b0;
      wr_other = 1'b0;
      wr_both  = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            wr_addr = clr_row_ff;
            wr_data = '0;
            wr_both = 1'b1;
         end
         S_IDLE: begin
            rd_addr = RowAw'(head.entry.row);
         end
         S_CELL: begin
            wr_data[col_ff] = value_ff;
            wr_cur          = write_ff;
         end
         S_STEP: begin
            priority if (step_cnt_ff == '0) begin
               rd_addr = RowLast;
            end else if (step_cnt_ff <= StepRows) begin
               rd_addr = RowAw'(step_cnt_ff - StepOne);
            end else begin
               rd_addr = '0;
            end
            wr_addr  = RowAw'(step_cnt_ff - StepFill);
            wr_data  = next_row;
            wr_other = step_cnt_ff >= StepFill;
         end
      endcase
      wr_a = wr_both || (wr_cur && !bank_ff) || (wr_other && bank_ff);
      wr_b = wr_both || (wr_cur && bank_ff) || (wr_other && !bank_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         bank_ff      <= 1'b0;
         clr_row_ff   <= '0;
         step_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_chan.ready && !(pop && head.entry.op == OP_NOP)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_CLEAR: begin
               clr_row_ff <= clr_row_ff + RowAw'(1);
               if (clr_row_ff == RowLast) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (pop) begin
                  unique case (head.entry.op)
                     OP_NOP: begin
                        rsp_valid_ff            <= 1'b1;
                        rsp_payload_ff.done_cmd <= head.entry.done_cmd;
                        rsp_payload_ff.alive    <= 1'b0;
                     end
                     OP_READ, OP_WRITE: begin
                        row_ff   <= RowAw'(head.entry.row);
                        col_ff   <= ColAw'(head.entry.col);
                        value_ff <= head.entry.value;
                        write_ff <= head.entry.op == OP_WRITE;
                        state_ff <= S_CELL;
                     end
                     OP_STEP: begin
                        step_cnt_ff <= '0;
                        state_ff    <= S_STEP;
                     end
                  endcase
               end
            end
            S_CELL: begin
               rsp_valid_ff            <= 1'b1;
               rsp_payload_ff.done_cmd <= write_ff ? CMD_WRITE : CMD_READ;
               rsp_payload_ff.alive    <= write_ff ? 1'b0 : word[col_ff];
               state_ff                <= S_IDLE;
            end
            S_STEP: begin
               step_cnt_ff <= step_cnt_ff + StepOne;
               win_up_ff   <= win_mid_ff;
               win_mid_ff  <= win_dn_ff;
               win_dn_ff   <= word;
               if (step_cnt_ff == StepLast) begin
                  bank_ff                 <= !bank_ff;
                  rsp_valid_ff            <= 1'b1;
                  rsp_payload_ff.done_cmd <= CMD_STEP;
                  rsp_payload_ff.alive    <= 1'b0;
                  state_ff                <= S_IDLE;
               end
            end
         endcase
      end
   end

endmodule

FILE: rtl/life_grid_generation_step_top.sv
// Top level of the toroidal life grid block: front end, task queue and back end.
//
// Holds a GRID_HEIGHT by GRID_WIDTH torus of cells in two row-wide RAM banks, one
// row per word. After reset a clearing pass writes both banks dead, one row a
// cycle, and req_chan.ready stays low while it runs. Requests pass a two-entry task
// queue, so new beats are taken while the back end works or a response waits. In
// the back end a cell write or read first reads the row, then updates it or selects
// the bit; an unused command or off-grid address is answered straight from idle;
// and a generation step sweeps the grid: it reads one row per cycle from the
// current bank's read port into a three-row window, writes one full next row per
// cycle into the other bank, then swaps banks.
module life_grid_generation_step_top #(
   parameter int GRID_WIDTH  = 128,
   parameter int GRID_HEIGHT = 128
) (
   input  logic      clock,
   input  logic      reset,
   lgs_req_if.sink   req_chan,
   lgs_rsp_if.source rsp_chan
);
   import lgs_pkg::*;

   queue_head_type head;
   logic           pop;
   logic           clearing;

   lgs_front #(.GRID_WIDTH(GRID_WIDTH), .GRID_HEIGHT(GRID_HEIGHT)) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .clearing (clearing),
      .pop      (pop),
      .head     (head)
   );

   lgs_back #(.GRID_WIDTH(GRID_WIDTH), .GRID_HEIGHT(GRID_HEIGHT)) u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .pop      (pop),
      .clearing (clearing),
      .rsp_chan (rsp_chan)
   );

endmodule

FILE: rtl/lgs_checker.sv
// Port-level assertions for the life grid block and their bind to the top level.
module lgs_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [lgs_pkg::CMD_WIDTH-1:0] rsp_done_cmd,
   input logic                          rsp_alive
);
   import lgs_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_done_cmd) && $stable(rsp_alive))
      else $error("response beat changed while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !req_ready && !rsp_valid)
      else $error("channel active right after reset");

   a_alive_read: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_alive |-> rsp_done_cmd == CMD_READ)
      else $error("live cell reported for a command other than read");

   a_no_accept_clear: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !(req_valid && req_ready))
      else $error("request taken during clearing pass");

endmodule

bind life_grid_generation_step_top lgs_checker u_lgs_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_chan.valid),
   .req_ready    (req_chan.ready),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .rsp_done_cmd (rsp_chan.payload.done_cmd),
   .rsp_alive    (rsp_chan.payload.alive)
);

FILE: test/testbench.sv
// Self-checking testbench for the toroidal life grid block with random handshake pacing.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import lgs_pkg::*;

   localparam int GRID_W = 128;
   localparam int GRID_H = 128;
   localparam int SETTLE_CYCLES = 2 * GRID_H + 40;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct {
      req_payload_type beat;
      bit              drain_first;
   } cmd_slot_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   lgs_req_if req_bus ();
   lgs_rsp_if rsp_bus ();

   life_grid_generation_step_top #(
      .GRID_WIDTH  (GRID_W),
      .GRID_HEIGHT (GRID_H)
   ) uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   logic [GRID_W-1:0] life_grid [GRID_H];
   cmd_slot_type      cmd_backlog [$];
   rsp_payload_type   cell_replies [$];
   int                beats_sent = 0;
   int                phase_len = 1;
   int                error_count = 0;
   int                cycle_count = 0;

   always #5 clock = ~clock;

   initial begin
      req_bus.valid   = 1'b0;
      req_bus.payload = '0;
      rsp_bus.ready   = 1'b0;
      foreach (life_grid[r]) life_grid[r] = '0;
   end

   task automatic advance_generation();
      logic [GRID_W-1:0] nxt [GRID_H];
      int up, dn, lf, rt, n;
      for (int r = 0; r < GRID_H; r++) begin
         up = (r + GRID_H - 1) % GRID_H;
         dn = (r + 1) % GRID_H;
         for (int c = 0; c < GRID_W; c++) begin
            lf = (c + GRID_W - 1) % GRID_W;
            rt = (c + 1) % GRID_W;
            n = life_grid[up][lf] + life_grid[up][c] + life_grid[up][rt]
              + life_grid[r][lf] + life_grid[r][rt]
              + life_grid[dn][lf] + life_grid[dn][c] + life_grid[dn][rt];
            if (life_grid[r][c])
               nxt[r][c] = (n == 2 || n == 3);
            else
               nxt[r][c] = (n == 3);
         end
      end
      foreach (life_grid[r]) life_grid[r] = nxt[r];
   endtask

   task automatic apply_life_cmd(input req_payload_type p);
      rsp_payload_type reply;
      bit on_grid;
      on_grid = (p.row < GRID_H) && (p.col < GRID_W);
      reply.done_cmd = p.cmd;
      reply.alive = 1'b0;
      case (p.cmd)
         CMD_WRITE: begin
            if (on_grid) life_grid[p.row][p.col] = p.value;
         end
         CMD_READ: begin
            if (on_grid) reply.alive = life_grid[p.row][p.col];
         end
         CMD_STEP: begin
            advance_generation();
         end
         default: begin
         end
      endcase
      cell_replies.push_back(reply);
   endtask

   task automatic queue_cmd(input cmd_type c, input int r, input int cl, input bit v,
                            input bit drain);
      cmd_slot_type s;
      s.beat.cmd = c;
      s.beat.row = r[ROW_WIDTH-1:0];
      s.beat.col = cl[COL_WIDTH-1:0];
      s.beat.value = v;
      s.drain_first = drain;
      cmd_backlog.push_back(s);
   endtask

   function automatic int send_idle_pct(input int sent);
      if (sent < phase_len) return 24;
      if (sent < 2 * phase_len) return 57;
      return 0;
   endfunction

   function automatic int recv_idle_pct(input int sent);
      if (sent < phase_len) return 57;
      if (sent < 2 * phase_len) return 24;
      return 0;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            apply_life_cmd(req_bus.payload);
            beats_sent++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (cmd_backlog.size() != 0 &&
                !(cmd_backlog[0].drain_first && cell_replies.size() != 0) &&
                $urandom_range(99) >= send_idle_pct(beats_sent)) begin
               req_bus.payload <= cmd_backlog[0].beat;
               req_bus.valid <= 1'b1;
               void'(cmd_backlog.pop_front());
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      rsp_payload_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (cell_replies.size() == 0) begin
               $display("%0t: unexpected beat done_cmd %0d alive %0d", $time,
                        rsp_bus.payload.done_cmd, rsp_bus.payload.alive);
               error_count++;
            end else begin
               want = cell_replies.pop_front();
               if (rsp_bus.payload.done_cmd !== want.done_cmd) begin
                  $display("%0t: done_cmd expected %0d actual %0d", $time,
                           want.done_cmd, rsp_bus.payload.done_cmd);
                  error_count++;
               end
               if (rsp_bus.payload.alive !== want.alive) begin
                  $display("%0t: alive expected %0d actual %0d", $time,
                           want.alive, rsp_bus.payload.alive);
                  error_count++;
               end
            end
         end
         rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct(beats_sent));
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("testbench failed");
         $finish;
      end
   end

   initial begin
      int r0, c0, steps;
      // Directed: empty grid, corner wrap, blinker, ignored fields, unused command.
      queue_cmd(CMD_READ, 0, 0, 1'b1, 1'b0);
      queue_cmd(CMD_READ, 127, 127, 1'b0, 1'b0);
      queue_cmd(CMD_WRITE, 0, 0, 1'b1, 1'b0);
      queue_cmd(CMD_WRITE, 0, 127, 1'b1, 1'b0);
      queue_cmd(CMD_WRITE, 127, 0, 1'b1, 1'b0);
      queue_cmd(CMD_READ, 0, 127, 1'b0, 1'b0);
      queue_cmd(CMD_NONE, 127, 127, 1'b1, 1'b0);
      queue_cmd(CMD_WRITE, 64, 63, 1'b1, 1'b0);
      queue_cmd(CMD_WRITE, 64, 64, 1'b1, 1'b0);
      queue_cmd(CMD_WRITE, 64, 65, 1'b1, 1'b0);
      queue_cmd(CMD_STEP, 127, 127, 1'b1, 1'b0);
      queue_cmd(CMD_READ, 127, 127, 1'b1, 1'b0);
      queue_cmd(CMD_READ, 0, 0, 1'b0, 1'b0);
      queue_cmd(CMD_READ, 63, 64, 1'b0, 1'b0);
      queue_cmd(CMD_READ, 65, 64, 1'b0, 1'b0);
      queue_cmd(CMD_READ, 64, 63, 1'b0, 1'b0);
      queue_cmd(CMD_WRITE, 64, 64, 1'b0, 1'b0);
      queue_cmd(CMD_STEP, 0, 0, 1'b0, 1'b0);
      queue_cmd(CMD_READ, 64, 63, 1'b0, 1'b0);
      queue_cmd(CMD_READ, 127, 127, 1'b0, 1'b0);
      for (int s = 0; s < 2; s++) begin
         r0 = $urandom_range(1) ? $urandom_range(127) : 126 + $urandom_range(3);
         c0 = $urandom_range(1) ? $urandom_range(127) : 126 + $urandom_range(3);
         for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
               queue_cmd(CMD_WRITE, (r0 + i) % GRID_H, (c0 + j) % GRID_W,
                         1'($urandom_range(1)), (i == 0 && j == 0));
         steps = 1 + $urandom_range(1);
         for (int k = 0; k < steps; k++)
            queue_cmd(CMD_STEP, $urandom_range(127), $urandom_range(127),
                      1'($urandom_range(1)), 1'b0);
         for (int i = -1; i < 4; i++)
            for (int j = -1; j < 4; j++)
               queue_cmd(CMD_READ, (r0 + i + GRID_H) % GRID_H, (c0 + j + GRID_W) % GRID_W,
                         1'($urandom_range(1)), 1'b0);
         for (int k = 0; k < 6; k++)
            queue_cmd(cmd_type'($urandom_range(3)), $urandom_range(127),
                      $urandom_range(127), 1'($urandom_range(1)), 1'b0);
      end
      phase_len = cmd_backlog.size() / 3;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (cmd_backlog.size() != 0 || req_bus.valid || cell_replies.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("testbench passed");
      else
         $display("testbench failed");
      $finish;
   end

endmodule
